[hdl/bgf_pkg.sv]
// bgf_pkg: shared widths, register codes, reset values and pipeline payload types
// for the bulge gravity field pipeline; no dependencies
package bgf_pkg;

  localparam int SQ_N   = 33;  // square root stages, one result bit each
  localparam int ADIV_N = 80;  // inner-field scale divider stages
  localparam int QDIV_N = 32;  // final quotient stages

  typedef enum logic [2:0] {
    CFG_BULGE_X     = 3'd0,
    CFG_BULGE_Y     = 3'd1,
    CFG_BULGE_Z     = 3'd2,
    CFG_BULGE_RADIUS = 3'd3,
    CFG_BULGE_MASS  = 3'd4,
    CFG_GRAV_CONST  = 3'd5
  } cfg_reg_t;

  localparam logic [31:0] CENTRE_RESET = 32'd0;
  localparam logic [30:0] RADIUS_RESET = 31'd65536;
  localparam logic [30:0] MASS_RESET   = 31'd65536;
  localparam logic [30:0] GRAV_RESET   = 31'd65536;

  // configuration seen by the datapath, with derived products
  typedef struct packed {
    logic [2:0][31:0] centre;
    logic [30:0]      rb;
    logic [61:0]      k;    // G * mb, Q30.32
    logic [92:0]      rb3;  // rb^3
  } bgf_cfg_t;

  // offset magnitudes, signs and distance
  typedef struct packed {
    logic [2:0]       dpos;
    logic [2:0][32:0] mag;
    logic [32:0]      r;
  } bgf_geo_t;

  // per-lane numerator and shared divisor
  typedef struct packed {
    logic [2:0]        dpos;
    logic [2:0][112:0] num;
    logic [98:0]       den;
    logic              zero;
  } bgf_quo_t;

  typedef struct packed {
    logic [2:0][31:0] field;
    logic             at_centre;
    logic             saturated;
  } bgf_res_t;

endpackage

[hdl/bgf_cfg.sv]
// bgf_cfg: configuration registers and derived constants G*mb and rb^3
// depends on bgf_pkg
module bgf_cfg import bgf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output bgf_cfg_t    cfg
);

  logic [2:0][31:0] centre_r;
  logic [30:0] rb_r, mass_r, grav_r;
  logic [61:0] k_r, rb2_r, rb3l_r, rb3h_r;
  logic [92:0] rb3_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_r <= {3{CENTRE_RESET}};
      rb_r     <= RADIUS_RESET;
      mass_r   <= MASS_RESET;
      grav_r   <= GRAV_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BULGE_X:      centre_r[0] <= cfg_data;
        CFG_BULGE_Y:      centre_r[1] <= cfg_data;
        CFG_BULGE_Z:      centre_r[2] <= cfg_data;
        CFG_BULGE_RADIUS: rb_r <= cfg_data[30:0];
        CFG_BULGE_MASS:   mass_r <= cfg_data[30:0];
        CFG_GRAV_CONST:   grav_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // derived constants are registered; rb^3 passes through rb2_r, rb3l_r/rb3h_r and rb3_r
  always_ff @(posedge clk) begin
    k_r    <= grav_r * mass_r;
    rb2_r  <= rb_r * rb_r;
    rb3l_r <= rb2_r[30:0] * rb_r;
    rb3h_r <= rb2_r[61:31] * rb_r;
    rb3_r  <= {31'b0, rb3l_r} + {rb3h_r, 31'b0};
  end

  assign cfg.centre = centre_r;
  assign cfg.rb     = rb_r;
  assign cfg.k      = k_r;
  assign cfg.rb3    = rb3_r;

endmodule

[hdl/bgf_front.sv]
// bgf_front: offset, squares, sum and pipelined integer square root
// depends on bgf_pkg
module bgf_front import bgf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [2:0][31:0] pos,
  input  logic [2:0][31:0] centre,
  output logic             geo_valid,
  output bgf_geo_t         geo
);

  logic [2:0][32:0] d_s, mag_s;
  logic [2:0]       dpos_s;
  logic [2:0][65:0] prod_s;
  logic [65:0]      sum_s;

  logic v1_r, v2_r, v3_r;
  logic [2:0] dpos1_r, dpos2_r, dpos3_r;
  logic [2:0][32:0] mag1_r, mag2_r, mag3_r;
  logic [2:0][64:0] sq2_r;
  logic [65:0] s3_r;

  logic             sv_r    [SQ_N];
  logic [65:0]      ss_r    [SQ_N];
  logic [35:0]      srem_r  [SQ_N];
  logic [32:0]      sroot_r [SQ_N];
  logic [2:0][32:0] smag_r  [SQ_N];
  logic [2:0]       sdpos_r [SQ_N];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_s[i]    = {pos[i][31], pos[i]} - {centre[i][31], centre[i]};
      mag_s[i]  = d_s[i][32] ? 33'(-d_s[i]) : d_s[i];
      dpos_s[i] = !d_s[i][32] && (d_s[i] != '0);
      prod_s[i] = mag1_r[i] * mag1_r[i];
    end
    sum_s = {1'b0, sq2_r[0]} + {1'b0, sq2_r[1]} + {1'b0, sq2_r[2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dpos1_r <= dpos_s;
      mag1_r  <= mag_s;
      dpos2_r <= dpos1_r;
      mag2_r  <= mag1_r;
      for (int i = 0; i < 3; i++) sq2_r[i] <= prod_s[i][64:0];
      dpos3_r <= dpos2_r;
      mag3_r  <= mag2_r;
      s3_r    <= sum_s;
    end
  end

  // restoring square root, two radicand bits per stage
  for (genvar j = 0; j < SQ_N; j++) begin : g_sq
    logic             vin;
    logic [65:0]      sin;
    logic [35:0]      rin, rsh, trial, rem_o;
    logic [32:0]      qin, root_o;
    logic [2:0][32:0] mgin;
    logic [2:0]       pin;
    logic             ge;

    if (j == 0) begin : g_first
      assign vin  = v3_r;
      assign sin  = s3_r;
      assign rin  = '0;
      assign qin  = '0;
      assign mgin = mag3_r;
      assign pin  = dpos3_r;
    end else begin : g_next
      assign vin  = sv_r[j-1];
      assign sin  = ss_r[j-1];
      assign rin  = srem_r[j-1];
      assign qin  = sroot_r[j-1];
      assign mgin = smag_r[j-1];
      assign pin  = sdpos_r[j-1];
    end

    assign rsh    = {rin[33:0], sin[2*(SQ_N-1-j)+1 -: 2]};
    assign trial  = {1'b0, qin, 2'b01};
    assign ge     = rsh >= trial;
    assign rem_o  = ge ? rsh - trial : rsh;
    assign root_o = {qin[31:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[j] <= 1'b0;
      else if (adv) sv_r[j] <= vin;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ss_r[j]    <= sin;
        srem_r[j]  <= rem_o;
        sroot_r[j] <= root_o;
        smag_r[j]  <= mgin;
        sdpos_r[j] <= pin;
      end
    end
  end

  assign geo_valid = sv_r[SQ_N-1];
  assign geo.dpos  = sdpos_r[SQ_N-1];
  assign geo.mag   = smag_r[SQ_N-1];
  assign geo.r     = sroot_r[SQ_N-1];

endmodule

[hdl/bgf_scale.sv]
// bgf_scale: inner/outer selection, inner scale divider and numerator/divisor build
// depends on bgf_pkg
module bgf_scale import bgf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  logic     geo_valid,
  input  bgf_geo_t geo,
  input  bgf_cfg_t cfg,
  output logic     quo_valid,
  output bgf_quo_t quo
);

  logic [34:0] w_s;
  logic [64:0] pwl_s, pwh_s;
  logic [95:0] kw_s;

  logic a1v_r, a2v_r;
  bgf_geo_t a1geo_r, a2geo_r;
  logic a1in_r, a2in_r, a1z_r, a2z_r;
  logic [64:0] pwl_r, pwh_r;
  logic [31:0] a2rem_r;
  logic [79:0] a2nlo_r;

  logic        av_r   [ADIV_N];
  logic [31:0] arem_r [ADIV_N];
  logic [79:0] anlo_r [ADIV_N];
  logic [79:0] aq_r   [ADIV_N];
  bgf_geo_t    ageo_r [ADIV_N];
  logic        ain_r  [ADIV_N];
  logic        az_r   [ADIV_N];

  logic [79:0]       m_s;
  logic [2:0][59:0]  p0_s, p1_s;
  logic [2:0][58:0]  p2_s;
  logic [65:0]       r2_s;

  logic b1v_r, b2v_r, b3v_r;
  logic [2:0] b1p_r, b2p_r;
  logic b1in_r, b2in_r, b1z_r, b2z_r;
  logic [2:0][59:0] p0_r, p1_r;
  logic [2:0][58:0] p2_r;
  logic [65:0] r2_r;
  logic [32:0] b1r_r;
  logic [2:0][112:0] num_r;
  logic [65:0] r3l_r, r3h_r;
  logic [98:0] r3_s;
  bgf_quo_t quo_r;

  // w = 4 rb - 3 r, meaningful only inside the bulge
  assign w_s   = {2'b0, cfg.rb, 2'b00} - ({2'b0, geo.r} + {1'b0, geo.r, 1'b0});
  assign pwl_s = cfg.k[30:0] * w_s[33:0];
  assign pwh_s = cfg.k[61:31] * w_s[33:0];
  assign kw_s  = {31'b0, pwl_r} + {pwh_r, 31'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1v_r <= 1'b0;
      a2v_r <= 1'b0;
    end else if (adv) begin
      a1v_r <= geo_valid;
      a2v_r <= a1v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1geo_r <= geo;
      a1in_r  <= geo.r <= {2'b0, cfg.rb};
      a1z_r   <= geo.r == '0;
      pwl_r   <= pwl_s;
      pwh_r   <= pwh_s;
      a2geo_r <= a1geo_r;
      a2in_r  <= a1in_r;
      a2z_r   <= a1z_r;
      // numerator is kw << 16; its top bits seed the remainder
      a2rem_r <= kw_s[95:64];
      a2nlo_r <= {kw_s[63:0], 16'b0};
    end
  end

  // long division by rb, one quotient bit per stage
  for (genvar j = 0; j < ADIV_N; j++) begin : g_adiv
    logic        vin, inin, zin, ge;
    logic [31:0] rin, rsh, rem_o;
    logic [79:0] nin, qin;
    bgf_geo_t    gin;

    if (j == 0) begin : g_first
      assign vin  = a2v_r;
      assign rin  = a2rem_r;
      assign nin  = a2nlo_r;
      assign qin  = '0;
      assign gin  = a2geo_r;
      assign inin = a2in_r;
      assign zin  = a2z_r;
    end else begin : g_next
      assign vin  = av_r[j-1];
      assign rin  = arem_r[j-1];
      assign nin  = anlo_r[j-1];
      assign qin  = aq_r[j-1];
      assign gin  = ageo_r[j-1];
      assign inin = ain_r[j-1];
      assign zin  = az_r[j-1];
    end

    assign rsh   = {rin[30:0], nin[ADIV_N-1-j]};
    assign ge    = rsh >= {1'b0, cfg.rb};
    assign rem_o = ge ? rsh - {1'b0, cfg.rb} : rsh;

    always_ff @(posedge clk) begin
      if (!rst_n) av_r[j] <= 1'b0;
      else if (adv) av_r[j] <= vin;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        arem_r[j] <= rem_o;
        anlo_r[j] <= nin;
        aq_r[j]   <= {qin[78:0], ge};
        ageo_r[j] <= gin;
        ain_r[j]  <= inin;
        az_r[j]   <= zin;
      end
    end
  end

  // one multiplicand for both cases: a inside, K << 16 outside
  always_comb begin
    m_s = ain_r[ADIV_N-1] ? aq_r[ADIV_N-1] : {2'b0, cfg.k, 16'b0};
    for (int i = 0; i < 3; i++) begin
      p0_s[i] = m_s[26:0]  * ageo_r[ADIV_N-1].mag[i];
      p1_s[i] = m_s[53:27] * ageo_r[ADIV_N-1].mag[i];
      p2_s[i] = m_s[79:54] * ageo_r[ADIV_N-1].mag[i];
    end
    r2_s = ageo_r[ADIV_N-1].r * ageo_r[ADIV_N-1].r;
  end

  assign r3_s = {33'b0, r3l_r} + {r3h_r, 33'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1v_r <= 1'b0;
      b2v_r <= 1'b0;
      b3v_r <= 1'b0;
    end else if (adv) begin
      b1v_r <= av_r[ADIV_N-1];
      b2v_r <= b1v_r;
      b3v_r <= b2v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1p_r  <= ageo_r[ADIV_N-1].dpos;
      b1in_r <= ain_r[ADIV_N-1];
      b1z_r  <= az_r[ADIV_N-1];
      b1r_r  <= ageo_r[ADIV_N-1].r;
      p0_r   <= p0_s;
      p1_r   <= p1_s;
      p2_r   <= p2_s;
      r2_r   <= r2_s;
      b2p_r  <= b1p_r;
      b2in_r <= b1in_r;
      b2z_r  <= b1z_r;
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= {53'b0, p0_r[i]} + {26'b0, p1_r[i], 27'b0} + {p2_r[i], 54'b0};
      end
      r3l_r <= r2_r[32:0] * b1r_r;
      r3h_r <= r2_r[65:33] * b1r_r;
      quo_r.dpos <= b2p_r;
      quo_r.num  <= num_r;
      quo_r.den  <= b2in_r ? {6'b0, cfg.rb3} : r3_s;
      quo_r.zero <= b2z_r;
    end
  end

  assign quo_valid = b3v_r;
  assign quo       = quo_r;

endmodule

[hdl/bgf_div.sv]
// bgf_div: per-lane quotient pipeline, saturation, sign and centre override
// depends on bgf_pkg
module bgf_div import bgf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  logic     quo_valid,
  input  bgf_quo_t quo,
  output logic     res_valid,
  output bgf_res_t res
);

  logic c0v_r;
  logic [2:0][98:0] c0rem_r;
  logic [2:0][31:0] c0nlo_r;
  logic [2:0]       c0big_r;
  logic [2:0]       c0p_r;
  logic [98:0]      c0den_r;
  logic             c0z_r;

  logic             dv_r   [QDIV_N];
  logic [2:0][98:0] drem_r [QDIV_N];
  logic [2:0][31:0] dnlo_r [QDIV_N];
  logic [2:0][31:0] dq_r   [QDIV_N];
  logic [2:0]       dbig_r [QDIV_N];
  logic [2:0]       dp_r   [QDIV_N];
  logic [98:0]      dden_r [QDIV_N];
  logic             dz_r   [QDIV_N];

  logic [2:0][31:0] lim_s, mg_s, f_s;
  logic [2:0]       sat_s;
  logic             resv_r;
  bgf_res_t         res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c0v_r <= 1'b0;
    else if (adv) c0v_r <= quo_valid;
  end

  // quotient of 2^32 or more means clipping
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c0rem_r[i] <= {18'b0, quo.num[i][112:32]};
        c0nlo_r[i] <= quo.num[i][31:0];
        c0big_r[i] <= {18'b0, quo.num[i][112:32]} >= quo.den;
      end
      c0p_r   <= quo.dpos;
      c0den_r <= quo.den;
      c0z_r   <= quo.zero;
    end
  end

  for (genvar j = 0; j < QDIV_N; j++) begin : g_qdiv
    logic             vin, zin;
    logic [2:0][98:0] rin, rem_o;
    logic [2:0][99:0] rsh;
    logic [2:0][31:0] nin, qin, q_o;
    logic [2:0]       bin, pin, ge;
    logic [98:0]      din;

    if (j == 0) begin : g_first
      assign vin = c0v_r;
      assign rin = c0rem_r;
      assign nin = c0nlo_r;
      assign qin = '0;
      assign bin = c0big_r;
      assign pin = c0p_r;
      assign din = c0den_r;
      assign zin = c0z_r;
    end else begin : g_next
      assign vin = dv_r[j-1];
      assign rin = drem_r[j-1];
      assign nin = dnlo_r[j-1];
      assign qin = dq_r[j-1];
      assign bin = dbig_r[j-1];
      assign pin = dp_r[j-1];
      assign din = dden_r[j-1];
      assign zin = dz_r[j-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rsh[i]   = {rin[i], nin[i][QDIV_N-1-j]};
        ge[i]    = rsh[i] >= {1'b0, din};
        rem_o[i] = ge[i] ? 99'(rsh[i] - {1'b0, din}) : rsh[i][98:0];
        q_o[i]   = {qin[i][30:0], ge[i]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[j] <= 1'b0;
      else if (adv) dv_r[j] <= vin;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        drem_r[j] <= rem_o;
        dnlo_r[j] <= nin;
        dq_r[j]   <= q_o;
        dbig_r[j] <= bin;
        dp_r[j]   <= pin;
        dden_r[j] <= din;
        dz_r[j]   <= zin;
      end
    end
  end

  // positive offset allows magnitude 2^31, negative 2^31-1
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lim_s[i] = dp_r[QDIV_N-1][i] ? 32'h8000_0000 : 32'h7fff_ffff;
      sat_s[i] = dbig_r[QDIV_N-1][i] || (dq_r[QDIV_N-1][i] > lim_s[i]);
      mg_s[i]  = sat_s[i] ? lim_s[i] : dq_r[QDIV_N-1][i];
      f_s[i]   = dp_r[QDIV_N-1][i] ? 32'(-mg_s[i]) : mg_s[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) resv_r <= 1'b0;
    else if (adv) resv_r <= dv_r[QDIV_N-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dz_r[QDIV_N-1]) begin
        res_r.field     <= '0;
        res_r.at_centre <= 1'b1;
        res_r.saturated <= 1'b0;
      end else begin
        res_r.field     <= f_s;
        res_r.at_centre <= 1'b0;
        res_r.saturated <= |sat_s;
      end
    end
  end

  assign res_valid = resv_r;
  assign res       = res_r;

endmodule

[hdl/bulge_gravity_field.sv]
// bulge_gravity_field: top level of the bulge gravity field pipeline
// depends on bgf_pkg, bgf_cfg, bgf_front, bgf_scale, bgf_div
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in_     | input     | in_valid / in_ready  | in_pos_x, in_pos_y, in_pos_z (s32 Q16.16)
//   out_    | output    | out_valid/out_ready  | out_field_x/y/z (s32), out_at_centre,
//           |           |                      | out_saturated
//   cfg_    | input     | cfg_valid/cfg_ready  | cfg_index (3 b), cfg_data (32 b)
//
// one transfer per cycle sustained while the skid register is empty; the pipeline
// contains the 33-stage square root, the 80-stage inner-scale divider and the 32-stage
// quotient divider
// synchronous active-low reset clears every valid bit and loads the register defaults
// the whole pipe advances together; it only holds when the output register and the
// skid register are both full, so a waiting result does not block the next input
// transfer; in_ready is a register output
// cfg_ready is always high; derived constants settle through registered products after a write
module bulge_gravity_field import bgf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_field_x,
  output logic [31:0] out_field_y,
  output logic [31:0] out_field_z,
  output logic        out_at_centre,
  output logic        out_saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  bgf_cfg_t cfg;
  logic     adv;
  logic     geo_valid, quo_valid, res_valid;
  bgf_geo_t geo;
  bgf_quo_t quo;
  bgf_res_t res;

  logic     out_valid_r, out_valid_nxt, sk_valid_r, sk_valid_nxt;
  logic     out_load, out_from_sk, sk_load, take;
  bgf_res_t out_r, sk_r;

  // pipe moves whenever the skid register is empty
  assign adv      = !sk_valid_r;
  assign in_ready = adv;

  bgf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bgf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .pos       ({in_pos_z, in_pos_y, in_pos_x}),
    .centre    (cfg.centre),
    .geo_valid (geo_valid),
    .geo       (geo)
  );

  bgf_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .geo_valid (geo_valid),
    .geo       (geo),
    .cfg       (cfg),
    .quo_valid (quo_valid),
    .quo       (quo)
  );

  bgf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .quo_valid (quo_valid),
    .quo       (quo),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register with one skid entry
  always_comb begin
    take          = out_valid_r && out_ready;
    out_load      = 1'b0;
    out_from_sk   = 1'b0;
    sk_load       = 1'b0;
    out_valid_nxt = out_valid_r;
    sk_valid_nxt  = sk_valid_r;
    priority if (sk_valid_r) begin
      if (take) begin
        out_load     = 1'b1;
        out_from_sk  = 1'b1;
        sk_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || take) begin
        out_load      = 1'b1;
        out_valid_nxt = 1'b1;
      end else begin
        sk_load      = 1'b1;
        sk_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sk_valid_r  <= sk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_r <= out_from_sk ? sk_r : res;
    if (sk_load)  sk_r  <= res;
  end

  assign out_valid     = out_valid_r;
  assign out_field_x   = out_r.field[0];
  assign out_field_y   = out_r.field[1];
  assign out_field_z   = out_r.field[2];
  assign out_at_centre = out_r.at_centre;
  assign out_saturated = out_r.saturated;

endmodule

[hdl/bgf_checker.sv]
// bgf_checker: port-level assertions for bulge_gravity_field, bound to the top level
// depends on bulge_gravity_field ports only
module bgf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_field_x,
  input logic [31:0] out_field_y,
  input logic [31:0] out_field_z,
  input logic        out_at_centre,
  input logic        out_saturated
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_field_x)
      && $stable(out_field_y) && $stable(out_field_z))
    else $error("result changed while stalled");

  // centre result is zero and never clipped
  a_centre: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_at_centre |-> out_field_x == 32'd0 && out_field_y == 32'd0
      && out_field_z == 32'd0 && !out_saturated)
    else $error("centre result not zero");

  // a clipped result shows a bound in some lane
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_field_x == 32'h7fff_ffff
      || out_field_x == 32'h8000_0000 || out_field_y == 32'h7fff_ffff
      || out_field_y == 32'h8000_0000 || out_field_z == 32'h7fff_ffff
      || out_field_z == 32'h8000_0000)
    else $error("saturated flag without bound value");

  // input only blocks when a result is waiting at the output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input blocked with empty output");

endmodule

bind bulge_gravity_field bgf_checker u_bgf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_field_x   (out_field_x),
  .out_field_y   (out_field_y),
  .out_field_z   (out_field_z),
  .out_at_centre (out_at_centre),
  .out_saturated (out_saturated)
);

[test/tb_bulge_gravity_field.sv]
// tb_bulge_gravity_field: self-checking testbench for the bulge gravity field pipeline
// depends on bgf_pkg and bulge_gravity_field; directed table first, then random phases,
// typed rows checked against their own values, all others against an in-bench fixed-point field calculator
`timescale 1ns / 1ps

module tb_bulge_gravity_field;
  import bgf_pkg::*;

  // unused register slots, writes there must change nothing
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  localparam int PIPE_DEPTH = 156;

  typedef struct {
    logic [31:0] fx, fy, fz;
    logic        ctr, sat;
  } field_t;

  typedef struct {
    logic [31:0] px, py, pz;
    bit          typed;    // expected value written into the row
    field_t      want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_field_x, out_field_y, out_field_z;
  logic        out_at_centre, out_saturated;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // bench copy of the register file
  logic [31:0] ctr_x, ctr_y, ctr_z;
  logic [30:0] radius, mass, grav;

  field_t expected_fields[$];
  bit     mismatch_seen = 1'b0;
  bit     sink_quiet = 1'b0;   // no new output stalls start while set
  bit     source_quiet = 1'b0; // no input gaps while set

  bulge_gravity_field i_dut (.*);

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // gap length: mostly none, often short, now and then long
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // field of the bulge at one position, exact integer steps on raw Q16.16 values
  function automatic field_t bulge_field(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    logic [31:0]        pos[3];
    logic [31:0]        ctr[3];
    logic signed [32:0] d[3];
    logic [32:0]        mag[3];
    logic [67:0]        sumsq, trial, r;
    logic [61:0]        k;
    logic [159:0]       v, scale, rb3;
    logic [33:0]        w;
    logic [31:0]        lim, comp[3];
    field_t             res;
    pos = '{px, py, pz};
    ctr = '{ctr_x, ctr_y, ctr_z};
    sumsq = '0;
    res = '{default: '0};
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed({pos[i][31], pos[i]}) - $signed({ctr[i][31], ctr[i]});
      mag[i] = (d[i] < 0) ? 33'(-d[i]) : 33'(d[i]);
      sumsq = sumsq + 68'(mag[i]) * 68'(mag[i]);
    end
    // bitwise integer square root
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      trial = r | (68'd1 << b);
      if (trial * trial <= sumsq) r = trial;
    end
    if (r == 0) begin
      res.ctr = 1'b1;
      return res;
    end
    k = 62'(grav) * 62'(mass);
    rb3 = 160'(radius) * 160'(radius) * 160'(radius);
    // inner scale is shared by the three lanes
    w = 34'(4 * 34'(radius)) - 34'(3 * r);
    scale = ((160'(k) * 160'(w)) << 16) / 160'(radius);
    for (int i = 0; i < 3; i++) begin
      if (r > 68'(radius))
        v = ((160'(k) * 160'(mag[i])) << 16) / (160'(r) * 160'(r) * 160'(r));
      else
        v = (scale * 160'(mag[i])) / rb3;
      lim = (d[i] > 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      if (v > 160'(lim)) begin
        res.sat = 1'b1;
        v = 160'(lim);
      end
      comp[i] = (d[i] > 0) ? -v[31:0] : v[31:0];
    end
    res.fx = comp[0];
    res.fy = comp[1];
    res.fz = comp[2];
    return res;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BULGE_X:      ctr_x = data;
      CFG_BULGE_Y:      ctr_y = data;
      CFG_BULGE_Z:      ctr_z = data;
      CFG_BULGE_RADIUS: radius = data[30:0];
      CFG_BULGE_MASS:   mass = data[30:0];
      CFG_GRAV_CONST:   grav = data[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one position transfer; typed rows bring their own expectation
  task automatic send_pos(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                          bit typed, field_t want);
    int gap;
    gap = source_quiet ? 0 : gap_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    do @(posedge clk); while (!in_ready);
    expected_fields.push_back(typed ? want : bulge_field(px, py, pz));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk);
  endtask

  // position near the centre, inside or around the bulge, or anywhere
  task automatic random_pos(output logic [31:0] p[3]);
    int          kind;
    logic [31:0] span, off;
    logic [31:0] ctr[3];
    ctr = '{ctr_x, ctr_y, ctr_z};
    kind = $urandom_range(0, 99);
    span = (radius > 31'h3FFF_FFFF) ? 32'h7FFF_FFFF : {radius, 1'b0};
    for (int i = 0; i < 3; i++) begin
      if (kind < 30)      off = $urandom();
      else if (kind < 65) off = $urandom_range(0, span);
      else if (kind < 90) off = $urandom_range(0, 32'h0010_0000);
      else                off = '0;
      if (kind < 90 && $urandom_range(0, 1)) off = -off;
      p[i] = ctr[i] + off;
    end
  endtask

  // sink side: random stalls unless quiet
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!sink_quiet && $urandom_range(0, 99) < 20) begin
      stall_left <= gap_len();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_blk
    field_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_fields.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h", $time,
                 out_field_x, out_field_y, out_field_z);
        mismatch_seen = 1'b1;
      end else begin
        want = expected_fields.pop_front();
        if (out_field_x !== want.fx) begin
          $display("%0t: field_x expected %h got %h", $time, want.fx, out_field_x);
          mismatch_seen = 1'b1;
        end
        if (out_field_y !== want.fy) begin
          $display("%0t: field_y expected %h got %h", $time, want.fy, out_field_y);
          mismatch_seen = 1'b1;
        end
        if (out_field_z !== want.fz) begin
          $display("%0t: field_z expected %h got %h", $time, want.fz, out_field_z);
          mismatch_seen = 1'b1;
        end
        if (out_at_centre !== want.ctr) begin
          $display("%0t: at_centre expected %b got %b", $time, want.ctr, out_at_centre);
          mismatch_seen = 1'b1;
        end
        if (out_saturated !== want.sat) begin
          $display("%0t: saturated expected %b got %b", $time, want.sat, out_saturated);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  initial begin : stim_blk
    stim_row_t   rows[$];
    field_t      none;
    logic [31:0] p[3];
    logic [31:0] cfg_val[6];
    none = '{default: '0};
    ctr_x = CENTRE_RESET;
    ctr_y = CENTRE_RESET;
    ctr_z = CENTRE_RESET;
    radius = RADIUS_RESET;
    mass = MASS_RESET;
    grav = GRAV_RESET;

    // directed rows under reset registers: centre 0, radius, mass and G all 1.0
    rows = '{
      // particle on the centre: zero field and flag
      '{32'h0, 32'h0, 32'h0, 1, '{32'h0, 32'h0, 32'h0, 1'b1, 1'b0}},
      // on the bulge edge along each axis: unit field pointing inward
      '{32'h0001_0000, 32'h0, 32'h0, 1, '{32'hFFFF_0000, 32'h0, 32'h0, 1'b0, 1'b0}},
      '{32'h0, 32'h0001_0000, 32'h0, 1, '{32'h0, 32'hFFFF_0000, 32'h0, 1'b0, 1'b0}},
      '{32'h0, 32'h0, 32'h0001_0000, 1, '{32'h0, 32'h0, 32'hFFFF_0000, 1'b0, 1'b0}},
      '{32'hFFFF_0000, 32'h0, 32'h0, 1, '{32'h0001_0000, 32'h0, 32'h0, 1'b0, 1'b0}},
      // smallest offsets, deep inside, and one point part way to the edge
      '{32'h1, 32'h0, 32'h0, 0, none},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, none},
      '{32'h0000_8000, 32'h0000_8000, 32'h0, 0, none},
      // just outside and far outside
      '{32'h0001_0001, 32'h0, 32'h0, 0, none},
      '{32'h0002_0000, 32'hFFFE_0000, 32'h0003_0000, 0, none},
      // extremes of the position range and an alternating bit pattern
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, none},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, none},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 0, none},
      '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 0, none}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send_pos(rows[i].px, rows[i].py, rows[i].pz, rows[i].typed, rows[i].want);
    repeat (120) begin
      random_pos(p);
      send_pos(p[0], p[1], p[2], 0, none);
    end

    for (int ph = 1; ph <= 10; ph++) begin
      // registers change only once the pipe is empty
      drain();
      case (ph)
        1: cfg_val = '{32'h0064_0000, 32'hFFCE_0000, 32'h0003_4000,
                       32'h000A_0000, 32'h03E8_0000, 32'h0000_8000};
        2: cfg_val = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        3: cfg_val = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001};
        4: cfg_val = '{32'h0, 32'h0, 32'h0, 32'h0002_0000, 32'h0, 32'h0001_0000};
        5: cfg_val = '{32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0};
        default: begin
          foreach (cfg_val[j]) cfg_val[j] = $urandom();
          if (cfg_val[CFG_BULGE_RADIUS][30:0] == 0) cfg_val[CFG_BULGE_RADIUS][0] = 1'b1;
          // keep the radius small in about half of the random phases so the inner branch gets hits
          if ($urandom_range(0, 1)) cfg_val[CFG_BULGE_RADIUS][30:22] = '0;
        end
      endcase
      write_reg(CFG_BULGE_X, cfg_val[0]);
      write_reg(CFG_BULGE_Y, cfg_val[1]);
      write_reg(CFG_BULGE_Z, cfg_val[2]);
      write_reg(CFG_BULGE_RADIUS, cfg_val[3]);
      write_reg(CFG_BULGE_MASS, cfg_val[4]);
      write_reg(CFG_GRAV_CONST, cfg_val[5]);
      write_reg(CFG_SPARE_LO, $urandom());
      write_reg(CFG_SPARE_HI, $urandom());
      // derived products pass through registers and must settle after a write
      repeat (4) @(posedge clk);
      source_quiet = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      repeat (123) begin
        random_pos(p);
        send_pos(p[0], p[1], p[2], 0, none);
      end
    end

    drain();
    repeat (PIPE_DEPTH + 20) @(posedge clk);
    if (!mismatch_seen)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
